@@ hdl/chained_slot_allocator_unit_macros.svh @@
// Assertion macros shared by the chained slot allocator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef CHAINED_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define CHAINED_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CSA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csa check failed");

// Next-cycle implication, disabled while reset is asserted
`define CSA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csa check failed");

`endif

@@ hdl/csa_pkg.sv @@
// Package for the chained slot allocator: sizes, marks, codes, state and bus types.
// No dependencies; imported by every module of the block.
`default_nettype none

package csa_pkg;

    // Table and level sizing
    localparam int TABLE_SLOTS = 128;
    localparam int LEVELS      = 3;
    localparam int BASE_REGS   = 3;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int LVL_IDX_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int BASE_IDX_W  = $clog2(BASE_REGS);

    // Field widths fixed by the interface
    localparam int VAL_W     = 7;
    localparam int LVL_W     = 2;
    localparam int LINK_W    = 8;
    localparam int CFG_IDX_W = 3;

    // Link table marks
    localparam logic [LINK_W-1:0] FREE_MARK = 8'hFF;
    localparam logic [LINK_W-1:0] END_MARK  = 8'h80;
    localparam logic [LINK_W-1:0] SLOT_LIM  = LINK_W'(TABLE_SLOTS);

    localparam logic [VAL_W-1:0] STOCK_MAX  = 7'd127;
    localparam logic [VAL_W-1:0] BASE_RESET = 7'd1;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOCK_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOCK_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOCK_C = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_LINK,
        S_LFIN,
        S_WALK
    } t_state;

    // Link table access for one cycle
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [LINK_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

@@ hdl/csa_link_mem.sv @@
// Link table memory: one write and one registered read per cycle.
// Per-entry valid bits make untouched entries read as free. Uses csa_pkg.
`default_nettype none

module csa_link_mem
    import csa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_req          i_req,
    output logic      [LINK_W-1:0] o_rdata
);

    logic [LINK_W-1:0]      r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [LINK_W-1:0]      r_rd_q;
    logic                   r_rd_valid;
    logic                   r_hit;
    logic [LINK_W-1:0]      r_hit_data;

    // Write the array and register the read word
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_q     <= r_mem[i_req.raddr];
        r_hit_data <= i_req.wdata;
    end

    // Track written entries and same-address collisions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_req.raddr];
            r_hit      <= i_req.we && (i_req.waddr == i_req.raddr);
        end
    end

    // Forward a colliding write, else show free for unwritten entries
    assign o_rdata = r_hit ? r_hit_data : (r_rd_valid ? r_rd_q : FREE_MARK);

endmodule

`default_nettype wire

@@ hdl/csa_seq.sv @@
// Sequencer of the chained slot allocator: config registers, level stock,
// slot scan and chain walk driving the shared link table port. Uses csa_pkg.
`default_nettype none
`include "chained_slot_allocator_unit_macros.svh"

module csa_seq
    import csa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_operation,
    input  wire logic [LVL_W-1:0] i_level_select,
    input  wire logic [VAL_W-1:0] i_operand_value,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VAL_W-1:0] i_cfg_wdata,
    input  wire logic [LINK_W-1:0] i_rdata,
    output t_mem_req              o_mem_req,
    output logic                  o_busy,
    output logic                  o_done,
    output logic                  o_success,
    output logic      [VAL_W-1:0] o_head_slot,
    output logic      [VAL_W-1:0] o_stock_left
);

    t_state r_state, n_state;

    logic [VAL_W-1:0]  r_base  [BASE_REGS];
    logic [VAL_W-1:0]  r_stock [LEVELS];

    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [SLOT_W-1:0] r_scan, n_scan;
    logic [VAL_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_prev, n_prev;
    logic [SLOT_W-1:0] r_head, n_head;
    logic              r_first, n_first;

    logic              r_done, n_done;
    logic              r_success, n_success;
    logic [VAL_W-1:0]  r_head_out, n_head_out;
    logic [VAL_W-1:0]  r_stock_out, n_stock_out;

    logic              stock_we;
    logic [VAL_W-1:0]  stock_wdata;

    logic              in_lvl_ok;
    logic [VAL_W-1:0]  in_stock;
    logic [VAL_W-1:0]  in_base;
    logic              alloc_bad;
    logic              free_bad;
    logic [VAL_W-1:0]  cur_stock;
    logic [VAL_W-1:0]  cur_base;
    logic [VAL_W-1:0]  stock_inc;
    logic              slot_free;
    logic              usable;
    logic              reached;
    logic              last_slot;
    logic              link_end;

    // Decode the incoming request
    assign in_lvl_ok = (int'(i_level_select) < LEVELS) && (int'(i_level_select) < BASE_REGS);
    assign in_stock  = in_lvl_ok ? r_stock[LVL_IDX_W'(i_level_select)] : '0;
    assign in_base   = in_lvl_ok ? r_base[BASE_IDX_W'(i_level_select)] : '0;
    assign alloc_bad = (i_operand_value == '0) || (in_stock < i_operand_value)
                       || ({1'b0, in_base} >= SLOT_LIM);
    assign free_bad  = {1'b0, i_operand_value} >= SLOT_LIM;

    // Shared scan/walk unit: one table word examined per cycle
    assign cur_stock = r_stock[LVL_IDX_W'(r_lvl)];
    assign cur_base  = r_base[BASE_IDX_W'(r_lvl)];
    assign stock_inc = (cur_stock == STOCK_MAX) ? cur_stock : cur_stock + 7'd1;
    assign slot_free = (i_rdata == FREE_MARK);
    assign usable    = slot_free && (LINK_W'(r_scan) != END_MARK);
    assign reached   = usable && ((r_cnt + 7'd1) == r_val);
    assign last_slot = (r_scan == SLOT_W'(TABLE_SLOTS - 1));
    assign link_end  = (i_rdata == END_MARK) || (i_rdata >= SLOT_LIM);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && in_lvl_ok) begin
                    if (i_operation == OP_ALLOC) begin
                        n_state = alloc_bad ? S_IDLE : S_COUNT;
                    end else begin
                        n_state = free_bad ? S_IDLE : S_WALK;
                    end
                end
            end
            S_COUNT: begin
                if (reached) begin
                    n_state = S_LINK;
                end else if (last_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_LINK: begin
                if (reached) begin
                    n_state = S_LFIN;
                end
            end
            S_LFIN: begin
                n_state = S_IDLE;
            end
            S_WALK: begin
                if (slot_free || link_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, table port and result
    always_comb begin
        n_lvl           = r_lvl;
        n_val           = r_val;
        n_scan          = r_scan;
        n_cnt           = r_cnt;
        n_prev          = r_prev;
        n_head          = r_head;
        n_first         = r_first;
        n_done          = 1'b0;
        n_success       = r_success;
        n_head_out      = r_head_out;
        n_stock_out     = r_stock_out;
        stock_we        = 1'b0;
        stock_wdata     = cur_stock;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_prev;
        o_mem_req.wdata = FREE_MARK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_lvl   = i_level_select;
                    n_val   = i_operand_value;
                    n_cnt   = '0;
                    n_first = 1'b1;
                    n_scan  = (i_operation == OP_ALLOC) ? SLOT_W'(in_base)
                                                        : SLOT_W'(i_operand_value);
                    // Reject at once: bad level, zero count, short stock, bad base, bad head
                    if (!in_lvl_ok || (i_operation == OP_ALLOC && alloc_bad)
                        || (i_operation == OP_FREE && free_bad)) begin
                        n_done      = 1'b1;
                        n_success   = 1'b0;
                        n_head_out  = '0;
                        n_stock_out = in_stock;
                    end
                end
            end
            S_COUNT: begin
                n_scan = r_scan + 1'b1;
                if (usable) begin
                    n_cnt = r_cnt + 7'd1;
                end
                if (reached) begin
                    // Enough free slots: rescan from the base and link
                    n_scan = SLOT_W'(cur_base);
                    n_cnt  = '0;
                end else if (last_slot) begin
                    n_done      = 1'b1;
                    n_success   = 1'b0;
                    n_head_out  = '0;
                    n_stock_out = cur_stock;
                end
            end
            S_LINK: begin
                n_scan = r_scan + 1'b1;
                if (usable) begin
                    if (r_cnt == '0) begin
                        n_head = r_scan;
                    end else begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_prev;
                        o_mem_req.wdata = LINK_W'(r_scan);
                    end
                    n_prev = r_scan;
                    n_cnt  = r_cnt + 7'd1;
                end
            end
            S_LFIN: begin
                // Close the chain and take the count from the stock
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_prev;
                o_mem_req.wdata = END_MARK;
                stock_we        = 1'b1;
                stock_wdata     = cur_stock - r_val;
                n_done          = 1'b1;
                n_success       = 1'b1;
                n_head_out      = VAL_W'(r_head);
                n_stock_out     = cur_stock - r_val;
            end
            S_WALK: begin
                if (slot_free) begin
                    // Head already free fails; a free successor ends the walk
                    n_done      = 1'b1;
                    n_success   = !r_first;
                    n_head_out  = '0;
                    n_stock_out = cur_stock;
                end else begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_scan;
                    o_mem_req.wdata = FREE_MARK;
                    stock_we        = 1'b1;
                    stock_wdata     = stock_inc;
                    n_first         = 1'b0;
                    if (link_end) begin
                        n_done      = 1'b1;
                        n_success   = 1'b1;
                        n_head_out  = '0;
                        n_stock_out = stock_inc;
                    end else begin
                        n_scan = SLOT_W'(i_rdata);
                    end
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
        o_mem_req.raddr = n_scan;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_lvl       <= n_lvl;
        r_val       <= n_val;
        r_scan      <= n_scan;
        r_cnt       <= n_cnt;
        r_prev      <= n_prev;
        r_head      <= n_head;
        r_first     <= n_first;
        r_success   <= n_success;
        r_head_out  <= n_head_out;
        r_stock_out <= n_stock_out;
    end

    // Configuration writes and level stock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BASE_REGS; k++) begin
                r_base[k] <= BASE_RESET;
            end
            for (int k = 0; k < LEVELS; k++) begin
                r_stock[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                CFG_BASE_A, CFG_BASE_B, CFG_BASE_C: begin
                    r_base[BASE_IDX_W'(i_cfg_index)] <= i_cfg_wdata;
                end
                CFG_STOCK_A, CFG_STOCK_B, CFG_STOCK_C: begin
                    if (int'(i_cfg_index - CFG_STOCK_A) < LEVELS) begin
                        r_stock[LVL_IDX_W'(i_cfg_index - CFG_STOCK_A)] <= i_cfg_wdata;
                    end
                end
                default: begin
                    r_stock[0] <= r_stock[0];
                end
            endcase
        end else if (stock_we) begin
            r_stock[LVL_IDX_W'(r_lvl)] <= stock_wdata;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_success    = r_success;
    assign o_head_slot  = r_head_out;
    assign o_stock_left = r_stock_out;

    // Checks
    `CSA_ASSERT_IMPL(a_done_when_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    `CSA_ASSERT_NEXT(a_accept_acts, i_clk, i_rst_n, i_start && r_state == S_IDLE, r_state != S_IDLE || r_done)
    `CSA_ASSERT_IMPL(a_count_below, i_clk, i_rst_n, r_state == S_COUNT, r_cnt < r_val)
    `CSA_ASSERT_IMPL(a_link_behind, i_clk, i_rst_n, r_state == S_LINK && o_mem_req.we, o_mem_req.waddr < r_scan)

endmodule

`default_nettype wire

@@ hdl/chained_slot_allocator_unit.sv @@
// Top level of the chained slot allocator: sequencer plus link table memory.
// Depends on csa_pkg, csa_seq and csa_link_mem.
`default_nettype none

// Usage:
// Request channel: drive i_operation, i_level_select and i_operand_value with
// i_start high; the request is taken at a clock edge where o_busy is low.
// Allocate (operation 0) links the first free slots at or above the level's
// base slot into a chain; free (operation 1) walks a chain from its head.
// Result channel: o_done is high for exactly one cycle with o_success,
// o_head_slot and o_stock_left; the receiver cannot stall, so sample it then.
// A request rejected on its level, count, stock, base or head answers in the
// cycle after it is taken. A successful allocate makes one pass from the base
// slot that counts free slots, a second pass that links them, and one step that
// closes the chain. An allocate that runs out of table answers once its count
// pass reaches the table end. Free frees one slot per step, with one more step
// when the walk stops on a free slot; a head already free fails. All steps are
// set by the single link table port. Configuration: i_cfg_we, i_cfg_index,
// i_cfg_wdata write a register at once; a stock start write also loads that
// stock. The user writes only while the block is idle; the block does not
// enforce it. Reset (synchronous, active low) makes every slot free, base
// slots 1 and stocks 0, and returns to idle with no result pending.
module chained_slot_allocator_unit
    import csa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic                 i_operation,
    input  wire logic [LVL_W-1:0]     i_level_select,
    input  wire logic [VAL_W-1:0]     i_operand_value,
    output logic                      o_done,
    output logic                      o_success,
    output logic      [VAL_W-1:0]     o_head_slot,
    output logic      [VAL_W-1:0]     o_stock_left,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VAL_W-1:0]     i_cfg_wdata
);

    t_mem_req          mem_req;
    logic [LINK_W-1:0] mem_rdata;

    // Sequencer
    csa_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_operation     (i_operation),
        .i_level_select  (i_level_select),
        .i_operand_value (i_operand_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rdata         (mem_rdata),
        .o_mem_req       (mem_req),
        .o_busy          (o_busy),
        .o_done          (o_done),
        .o_success       (o_success),
        .o_head_slot     (o_head_slot),
        .o_stock_left    (o_stock_left)
    );

    // Link table
    csa_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for chained_slot_allocator_unit: allocate and free requests
// with random gaps, checked against a link table predictor. Uses csa_pkg and the DUT.

import csa_pkg::*;

typedef struct packed {
    logic             granted;
    logic [VAL_W-1:0] head;
    logic [VAL_W-1:0] stock_left;
} t_outcome;

// Predicts each request from its own copy of the link table, stocks and base slots,
// and holds the outcomes still owed by the block.
class slot_chain_scoreboard;
    logic [LINK_W-1:0] links [TABLE_SLOTS];
    logic [VAL_W-1:0]  stock [LEVELS];
    logic [VAL_W-1:0]  base  [BASE_REGS];
    t_outcome          queued_outcomes [$];
    int                mismatches;

    function new();
        foreach (links[s]) links[s] = FREE_MARK;
        foreach (stock[k]) stock[k] = '0;
        foreach (base[k]) base[k] = BASE_RESET;
        mismatches = 0;
    endfunction

    // A stock start write also reloads that level's stock
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] v);
        case (idx)
            CFG_BASE_A:  base[0] = v;
            CFG_BASE_B:  base[1] = v;
            CFG_BASE_C:  base[2] = v;
            CFG_STOCK_A: stock[0] = v;
            CFG_STOCK_B: stock[1] = v;
            CFG_STOCK_C: stock[2] = v;
            default: ;
        endcase
    endfunction

    function bit slot_open(int s);
        return s < TABLE_SLOTS && s != int'(END_MARK) && links[s] == FREE_MARK;
    endfunction

    // Link the first open slots at or above the base into a rising chain
    function t_outcome grant_chain(int lvl, int count);
        t_outcome o;
        int       avail;
        int       made;
        int       prev;
        o = '0;
        o.stock_left = stock[lvl];
        avail = 0;
        made = 0;
        prev = 0;
        if (count == 0 || stock[lvl] < count || base[lvl] >= TABLE_SLOTS) return o;
        for (int s = int'(base[lvl]); s < TABLE_SLOTS; s++)
            if (slot_open(s)) avail++;
        if (avail < count) return o;
        for (int s = int'(base[lvl]); s < TABLE_SLOTS && made < count; s++) begin
            if (slot_open(s)) begin
                if (made == 0) o.head = s[VAL_W-1:0];
                else links[prev] = s[LINK_W-1:0];
                links[s] = END_MARK;
                prev = s;
                made++;
            end
        end
        stock[lvl] = stock[lvl] - count[VAL_W-1:0];
        o.granted = 1'b1;
        o.stock_left = stock[lvl];
        return o;
    endfunction

    // Walk from the head, freeing slots; stop at the end mark or a stale link
    function t_outcome release_chain(int lvl, int head);
        t_outcome o;
        int       cur;
        int       nxt;
        o = '0;
        o.stock_left = stock[lvl];
        if (head >= TABLE_SLOTS || links[head] == FREE_MARK) return o;
        cur = head;
        while (1) begin
            nxt = int'(links[cur]);
            links[cur] = FREE_MARK;
            if (stock[lvl] < STOCK_MAX) stock[lvl] = stock[lvl] + 1'b1;
            if (nxt == int'(END_MARK) || nxt >= TABLE_SLOTS || links[nxt] == FREE_MARK)
                break;
            cur = nxt;
        end
        o.granted = 1'b1;
        o.stock_left = stock[lvl];
        return o;
    endfunction

    function void note_request(logic op, logic [LVL_W-1:0] lvl, logic [VAL_W-1:0] val);
        t_outcome o;
        o = '0;
        if (lvl < LEVELS && lvl < BASE_REGS)
            o = (op == OP_ALLOC) ? grant_chain(int'(lvl), int'(val))
                                 : release_chain(int'(lvl), int'(val));
        queued_outcomes.push_back(o);
    endfunction

    function void check_result(logic ok, logic [VAL_W-1:0] head, logic [VAL_W-1:0] left);
        t_outcome want;
        if (queued_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: success=%0b head=%0d stock=%0d", ok, head, left);
            return;
        end
        want = queued_outcomes.pop_front();
        if (ok !== want.granted || head !== want.head || left !== want.stock_left) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected success=%0b head=%0d stock=%0d, got %0b %0d %0d",
                         want.granted, want.head, want.stock_left, ok, head, left);
        end
    endfunction

    // A used slot that no other used slot links to
    function int pick_chain_head();
        bit linked [TABLE_SLOTS];
        int heads [$];
        foreach (linked[s]) linked[s] = 1'b0;
        foreach (links[s])
            if (links[s] != FREE_MARK && links[s] < TABLE_SLOTS) linked[links[s]] = 1'b1;
        foreach (links[s])
            if (links[s] != FREE_MARK && !linked[s]) heads.push_back(s);
        if (heads.size() == 0) return -1;
        return heads[$urandom_range(0, heads.size() - 1)];
    endfunction

    // Any used slot, often the middle of a chain
    function int pick_used_slot();
        int used [$];
        foreach (links[s])
            if (links[s] != FREE_MARK) used.push_back(s);
        if (used.size() == 0) return -1;
        return used[$urandom_range(0, used.size() - 1)];
    endfunction
endclass

module tb_top;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 134;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 operation = OP_ALLOC;
    logic [LVL_W-1:0]     level_select = '0;
    logic [VAL_W-1:0]     operand_value = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE_A;
    logic [VAL_W-1:0]     cfg_wdata = '0;
    wire                  busy;
    wire                  done;
    wire                  success;
    wire [VAL_W-1:0]      head_slot;
    wire [VAL_W-1:0]      stock_left;

    slot_chain_scoreboard sb = new();
    bit                   burst_mode = 1'b0;
    int                   quiet_cycles = 0;

    chained_slot_allocator_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_operation     (operation),
        .i_level_select  (level_select),
        .i_operand_value (operand_value),
        .o_done          (done),
        .o_success       (success),
        .o_head_slot     (head_slot),
        .o_stock_left    (stock_left),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Check every result on its strobe cycle
    always @(posedge clk) begin
        if (rst_n && done) sb.check_result(success, head_slot, stock_left);
    end

    // Abort when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || cfg_we) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return '0;
        if (r < 35) return STOCK_MAX;
        if (r < 70) return VAL_W'($urandom_range(0, 16));
        return VAL_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [VAL_W-1:0] pick_stock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 40) return STOCK_MAX;
        return VAL_W'($urandom_range(20, 127));
    endfunction

    // Hold the request until the block takes it, then idle for a random gap unless in burst mode
    task automatic issue(input logic op, input logic [LVL_W-1:0] lvl,
                         input logic [VAL_W-1:0] val);
        int gap;
        start <= 1'b1;
        operation <= op;
        level_select <= lvl;
        operand_value <= val;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(op, lvl, val);
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every owed result is back and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.queued_outcomes.size() != 0) @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
    endtask

    task automatic load_settings(input logic [VAL_W-1:0] b0, b1, b2, s0, s1, s2);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [VAL_W-1:0]     val [6];
        idx = '{CFG_BASE_A, CFG_BASE_B, CFG_BASE_C, CFG_STOCK_A, CFG_STOCK_B, CFG_STOCK_C};
        val = '{b0, b1, b2, s0, s1, s2};
        wait_idle();
        for (int k = 0; k < 6; k++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_wdata <= val[k];
            @(posedge clk);
            sb.write_reg(idx[k], val[k]);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly allocates and frees of live chains, some bad heads and dead levels
    task automatic send_random_request(output bit counted);
        int               r;
        int               slot;
        logic             op;
        logic [LVL_W-1:0] lvl;
        logic [VAL_W-1:0] val;
        r = $urandom_range(0, 99);
        lvl = LVL_W'($urandom_range(0, LEVELS - 1));
        op = OP_ALLOC;
        val = VAL_W'($urandom_range(1, 6));
        if (r < 45) begin
            if ($urandom_range(0, 99) < 15) val = VAL_W'($urandom_range(7, 40));
            else if ($urandom_range(0, 99) < 6) val = VAL_W'($urandom_range(0, 127));
        end else if (r < 82) begin
            slot = ($urandom_range(0, 4) == 0) ? sb.pick_used_slot() : sb.pick_chain_head();
            if (slot >= 0) begin
                op = OP_FREE;
                val = slot[VAL_W-1:0];
            end
        end else if (r < 91) begin
            op = OP_FREE;
            val = VAL_W'($urandom_range(0, 127));
        end else if (r < 95) begin
            op = 1'($urandom_range(0, 1));
            lvl = LVL_W'(LEVELS);
            val = VAL_W'($urandom_range(0, 127));
        end else begin
            op = 1'($urandom_range(0, 1));
            lvl = LVL_W'($urandom_range(0, 3));
            val = VAL_W'($urandom_range(0, 127));
        end
        issue(op, lvl, val);
        counted = (lvl < LEVELS);
    endtask

    initial begin
        int sent;
        bit counted;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no stock, and an unused level
        issue(OP_ALLOC, 0, 1);
        issue(OP_ALLOC, LVL_W'(LEVELS), 5);
        issue(OP_FREE, LVL_W'(LEVELS), 0);

        load_settings(7'd0, 7'd127, 7'd64, 7'd127, 7'd127, 7'd5);
        issue(OP_ALLOC, 0, 0);      // zero count
        issue(OP_ALLOC, 0, 3);      // chain 0-1-2
        issue(OP_ALLOC, 1, 2);      // runs past the table end
        issue(OP_ALLOC, 1, 1);      // last slot
        issue(OP_ALLOC, 2, 6);      // short stock
        issue(OP_ALLOC, 2, 5);
        issue(OP_ALLOC, 0, 124);    // stock covers it, table does not
        issue(OP_FREE, 0, 1);       // free from the middle of a chain
        issue(OP_FREE, 0, 0);       // head now links to a free slot
        issue(OP_FREE, 0, 127);     // stock saturates
        issue(OP_FREE, 2, 3);       // head already free
        issue(OP_FREE, 2, 64);
        issue(OP_ALLOC, 0, 127);    // longest chain
        issue(OP_ALLOC, 1, 1);
        issue(OP_FREE, 1, 0);       // longest walk
        issue(OP_FREE, 1, 127);

        // Random phases, each under its own settings
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                load_settings(7'd0, 7'd0, 7'd0, 7'd127, 7'd127, 7'd127);
            else if (p == PHASES - 1)
                load_settings(7'd127, 7'd100, 7'd0, 7'd0, 7'd127, 7'd60);
            else
                load_settings(pick_base(), pick_base(), pick_base(),
                              pick_stock(), pick_stock(), pick_stock());
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (sent % 32 == 0) burst_mode = ($urandom_range(0, 3) == 0);
                send_random_request(counted);
                if (counted) sent++;
            end
            burst_mode = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.queued_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
